// ----- rtl/core/dsu_pkg.sv -----
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants for the disjoint-set union-find core.
// ----------------------------------------------------------------------------
package dsu_pkg;

  // field widths fixed by the item format
  localparam int ELEM_W = 5;
  localparam int CNT_W  = 6;
  localparam int SZ_W   = 6;
  localparam int REQ_W  = 2;

  // merged set sizes saturate here
  localparam logic [SZ_W-1:0] SZ_MAX = '1;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_UNION = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_FIND_B,
    ST_SIZE_A,
    ST_MERGE,
    ST_DONE
  } state_t;

  // one result item
  typedef struct packed {
    logic              same_set;
    logic [ELEM_W-1:0] root;
    logic [CNT_W-1:0]  set_count;
    logic              bad_index;
  } result_t;

endpackage

// ----- rtl/core/disjoint_set_union_find_core.sv -----
// Sequence: a union steps from accept through FIND_A, FIND_B, SIZE_A and MERGE to DONE;
//   a query or same-set union skips SIZE_A and MERGE; a bad index or unknown request goes to DONE.
// Clear writes every parent/size entry, one parent/size entry written per cycle.
// One item at a time: the next is taken in the cycle after the result is issued.
// Reset: synchronous active-low; afterwards a clearing pass initializes both tables
//   before the first item is taken.
// ----------------------------------------------------------------------------
// disjoint_set_union_find_core
// Union-find store with union by size, sequenced over two table RAMs.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_core
  import dsu_pkg::*;
#(
  parameter int ELEMENTS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [ELEM_W-1:0] in_elem_a,
  input  logic [ELEM_W-1:0] in_elem_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_same_set,
  output logic [ELEM_W-1:0] out_root,
  output logic [CNT_W-1:0]  out_set_count,
  output logic              out_bad_index
);

  localparam int IDX_W = $clog2(ELEMENTS);
  localparam int LIM   = (ELEMENTS > 63) ? 63 : ELEMENTS;

  logic [CNT_W-1:0] elem_cnt_r;
  logic [CNT_W-1:0] live_cnt;
  logic             out_valid_r;
  result_t          out_res_r;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  logic             par_we;
  logic [IDX_W-1:0] par_waddr;
  logic [IDX_W-1:0] par_wdata;
  logic [IDX_W-1:0] par_raddr;
  logic [IDX_W-1:0] par_rdata;
  logic             sz_we;
  logic [IDX_W-1:0] sz_waddr;
  logic [SZ_W-1:0]  sz_wdata;
  logic [IDX_W-1:0] sz_raddr;
  logic [SZ_W-1:0]  sz_rdata;

  // element count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r <= CNT_W'(32);
    end else if (cfg_wr_en) begin
      elem_cnt_r <= cfg_wr_data;
    end
  end

  // count in use, limited to the table depth and to 63
  assign live_cnt = (elem_cnt_r > CNT_W'(LIM)) ? CNT_W'(LIM) : elem_cnt_r;

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_same_set  = out_res_r.same_set;
  assign out_root      = out_res_r.root;
  assign out_set_count = out_res_r.set_count;
  assign out_bad_index = out_res_r.bad_index;

  // sequencer
  dsu_ctrl #(
    .ELEMENTS (ELEMENTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .live_cnt    (live_cnt),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_elem_a   (in_elem_a),
    .in_elem_b   (in_elem_b),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .par_we      (par_we),
    .par_waddr   (par_waddr),
    .par_wdata   (par_wdata),
    .par_raddr   (par_raddr),
    .par_rdata   (par_rdata),
    .sz_we       (sz_we),
    .sz_waddr    (sz_waddr),
    .sz_wdata    (sz_wdata),
    .sz_raddr    (sz_raddr),
    .sz_rdata    (sz_rdata)
  );

  // parent link table
  dsu_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ELEMENTS)
  ) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  // set size table
  dsu_ram #(
    .WIDTH (SZ_W),
    .DEPTH (ELEMENTS)
  ) u_sz_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

endmodule

// ----- rtl/core/dsu_ram.sv -----
// ----------------------------------------------------------------------------
// dsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/dsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer for clear sweeps, root walks and the union merge step.
// ----------------------------------------------------------------------------
module dsu_ctrl
  import dsu_pkg::*;
#(
  parameter int ELEMENTS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [CNT_W-1:0]            live_cnt,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [REQ_W-1:0]            in_req_type,
  input  logic [ELEM_W-1:0]           in_elem_a,
  input  logic [ELEM_W-1:0]           in_elem_b,
  output logic                        res_valid,
  input  logic                        res_ready,
  output result_t                     res,
  output logic                        par_we,
  output logic [$clog2(ELEMENTS)-1:0] par_waddr,
  output logic [$clog2(ELEMENTS)-1:0] par_wdata,
  output logic [$clog2(ELEMENTS)-1:0] par_raddr,
  input  logic [$clog2(ELEMENTS)-1:0] par_rdata,
  output logic                        sz_we,
  output logic [$clog2(ELEMENTS)-1:0] sz_waddr,
  output logic [SZ_W-1:0]             sz_wdata,
  output logic [$clog2(ELEMENTS)-1:0] sz_raddr,
  input  logic [SZ_W-1:0]             sz_rdata
);

  localparam int IDX_W    = $clog2(ELEMENTS);
  localparam int CNT_INIT = (ELEMENTS < 32) ? ELEMENTS : 32;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENTS - 1);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic               clr_req_r, clr_req_nxt;
  logic [CNT_W-1:0]   sets_left_r, sets_left_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [ELEM_W-1:0]  b_r, b_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   ra_r, ra_nxt;
  logic [SZ_W-1:0]    sza_r, sza_nxt;
  result_t            res_r, res_nxt;

  logic [IDX_W-1:0]   a_idx;
  logic [IDX_W-1:0]   b_idx;
  logic               idx_bad;
  logic               link_eq;
  logic               b_wins;
  logic [IDX_W-1:0]   win_idx;
  logic [IDX_W-1:0]   lose_idx;
  logic [SZ_W:0]      size_sum;
  logic [CNT_W-1:0]   cnt_dec;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      clr_req_r   <= 1'b0;
      sets_left_r <= CNT_W'(CNT_INIT);
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_req_r   <= clr_req_nxt;
      sets_left_r <= sets_left_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    b_r   <= b_nxt;
    cur_r <= cur_nxt;
    ra_r  <= ra_nxt;
    sza_r <= sza_nxt;
    res_r <= res_nxt;
  end

  // index mapping and range check
  assign a_idx   = IDX_W'(in_elem_a);
  assign b_idx   = IDX_W'(b_r);
  assign idx_bad = ({1'b0, in_elem_a} >= live_cnt) || ({1'b0, in_elem_b} >= live_cnt);

  // shared compare / add unit
  assign link_eq  = (cur_r == par_rdata);
  assign b_wins   = (sza_r < sz_rdata);
  assign win_idx  = b_wins ? cur_r : ra_r;
  assign lose_idx = b_wins ? ra_r : cur_r;
  assign size_sum = {1'b0, sza_r} + {1'b0, sz_rdata};
  assign cnt_dec  = (sets_left_r != '0) ? (sets_left_r - CNT_W'(1)) : sets_left_r;

  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    clr_req_nxt   = clr_req_r;
    sets_left_nxt = sets_left_r;
    req_nxt       = req_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    ra_nxt        = ra_r;
    sza_nxt       = sza_r;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    par_we        = 1'b0;
    par_waddr     = clr_idx_r;
    par_wdata     = clr_idx_r;
    par_raddr     = cur_r;
    sz_we         = 1'b0;
    sz_waddr      = clr_idx_r;
    sz_wdata      = SZ_W'(1);
    sz_raddr      = ra_r;

    unique case (state_r)
      ST_CLEAR: begin
        par_we = 1'b1;
        sz_we  = 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          clr_req_nxt = 1'b0;
          if (clr_req_r) begin
            sets_left_nxt     = live_cnt;
            res_nxt.same_set  = 1'b0;
            res_nxt.root      = '0;
            res_nxt.set_count = live_cnt;
            res_nxt.bad_index = 1'b0;
            state_nxt         = ST_DONE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt           = in_req_type;
          b_nxt             = in_elem_b;
          cur_nxt           = a_idx;
          par_raddr         = a_idx;
          res_nxt.same_set  = 1'b0;
          res_nxt.root      = '0;
          res_nxt.set_count = sets_left_r;
          res_nxt.bad_index = 1'b0;
          case (in_req_type)
            REQ_CLEAR: begin
              clr_idx_nxt = '0;
              clr_req_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            REQ_UNION, REQ_QUERY: begin
              if (idx_bad) begin
                res_nxt.bad_index = 1'b1;
                state_nxt         = ST_DONE;
              end else begin
                state_nxt = ST_FIND_A;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // walk the first element up to its root
      ST_FIND_A: begin
        if (link_eq) begin
          ra_nxt    = cur_r;
          cur_nxt   = b_idx;
          par_raddr = b_idx;
          state_nxt = ST_FIND_B;
        end else begin
          cur_nxt   = par_rdata;
          par_raddr = par_rdata;
        end
      end

      // walk the second element; cur_r ends up holding its root
      ST_FIND_B: begin
        if (link_eq) begin
          res_nxt.root      = ELEM_W'(ra_r);
          res_nxt.set_count = sets_left_r;
          res_nxt.bad_index = 1'b0;
          if (ra_r == cur_r) begin
            res_nxt.same_set = 1'b1;
            state_nxt        = ST_DONE;
          end else if (req_r == REQ_UNION) begin
            sz_raddr  = ra_r;
            state_nxt = ST_SIZE_A;
          end else begin
            res_nxt.same_set = 1'b0;
            state_nxt        = ST_DONE;
          end
        end else begin
          cur_nxt   = par_rdata;
          par_raddr = par_rdata;
        end
      end

      // capture first root size, fetch second
      ST_SIZE_A: begin
        sza_nxt   = sz_rdata;
        sz_raddr  = cur_r;
        state_nxt = ST_MERGE;
      end

      // link smaller root under larger, tie keeps first root
      ST_MERGE: begin
        sz_we             = 1'b1;
        sz_waddr          = win_idx;
        sz_wdata          = size_sum[SZ_W] ? SZ_MAX : size_sum[SZ_W-1:0];
        par_we            = 1'b1;
        par_waddr         = lose_idx;
        par_wdata         = win_idx;
        sets_left_nxt     = cnt_dec;
        res_nxt.same_set  = 1'b0;
        res_nxt.root      = ELEM_W'(win_idx);
        res_nxt.set_count = cnt_dec;
        res_nxt.bad_index = 1'b0;
        state_nxt         = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
